[rtl/dds_pkg.sv]
package dds_pkg;

   localparam int MAX_OBJECTS_DEFAULT = 256;
   localparam int COORD_BITS_DEFAULT  = 12;

   // fixed field widths of the ports
   localparam int POS_W      = 12;
   localparam int SCORE_W    = 16;
   localparam int MINDIST_W  = 24;
   localparam int COUNT_W    = 9;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   // reset values: 0.9 in Q1.15 and 5.0 squared
   localparam logic [SCORE_W-1:0]   THRESH_RESET  = 16'd29491;
   localparam logic [MINDIST_W-1:0] MINDIST_RESET = 24'd25;

   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DISTANCE_SQ = 1'd1;

   localparam logic [STATUS_W-1:0] STATUS_BELOW     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_STORED    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   typedef struct packed {
      logic busy;
      logic hit;
   } dist_status_type;

endpackage

[rtl/detection_duplicate_suppressor_core.sv]
// Channel  Direction  Payload
// req_     in         tdata: pos_x[11:0] pos_y[23:12] match_score[39:24]; tuser: start_new_frame
// rsp_     out        tdata: status[1:0] object_count[10:2], zero above
// csr_     in         wr_en, index, wdata: score_threshold, min_distance_sq
//
// A request that is scanned is accepted, then checked; the scan reads one stored point per cycle
// from the point memory, then a three-stage distance pipeline drains before the verdict is
// registered for the response. A request below the score threshold skips the scan and the drain,
// one against an empty table skips the scan. Reset (synchronous, active high) empties the table
// and restores register defaults. A waiting response does not block the next request; a new
// result waits for rsp_tready.
module detection_duplicate_suppressor_core #(
   parameter int MAX_OBJECTS = dds_pkg::MAX_OBJECTS_DEFAULT,
   parameter int COORD_BITS  = dds_pkg::COORD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pos_x[11:0], pos_y[23:12], match_score[39:24]
   input  logic [dds_pkg::REQ_DATA_W-1:0]    req_tdata,
   // start_new_frame
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status[1:0], object_count[10:2], zeros above
   output logic [dds_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [dds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dds_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_OBJECTS + 1);
   localparam int IDX_W  = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
   localparam int PT_W   = 2 * COORD_BITS;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]                       state_ff, state_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [IDX_W-1:0]                 rd_idx_ff, rd_idx_in;
   logic                             hit_ff, hit_in;
   logic [COORD_BITS-1:0]            x_ff, y_ff;
   logic signed [dds_pkg::SCORE_W-1:0] score_ff, thresh_ff;
   logic [dds_pkg::MINDIST_W-1:0]    min_dist_ff;
   logic [dds_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic                             rsp_valid_ff;
   logic [dds_pkg::RSP_DATA_W-1:0]   rsp_data_ff;

   logic                             req_fire;
   logic                             issue;
   logic                             wr_en;
   logic                             rsp_free;
   logic                             last_read;
   logic [PT_W-1:0]                  rd_point;
   dds_pkg::dist_status_type         dist_res;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign issue      = (state_ff == ST_SCAN);
   assign last_read  = (CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff   <= dds_pkg::THRESH_RESET;
         min_dist_ff <= dds_pkg::MINDIST_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            dds_pkg::CSR_SCORE_THRESHOLD: thresh_ff <= csr_wdata[dds_pkg::SCORE_W-1:0];
            dds_pkg::CSR_MIN_DISTANCE_SQ: min_dist_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      hit_in    = hit_ff | dist_res.hit;
      status_in = status_ff;
      wr_en     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               hit_in   = 1'b0;
               state_in = ST_CHECK;
               if (req_tuser) begin
                  count_in = '0;
               end
            end
         end
         ST_CHECK: begin
            rd_idx_in = '0;
            if (!(score_ff > thresh_ff)) begin
               status_in = dds_pkg::STATUS_BELOW;
               state_in  = ST_OUT;
            end else if (count_ff == '0) begin
               state_in = ST_DRAIN;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_read) begin
               state_in = ST_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            // decide once the last distance has been compared
            if (!dist_res.busy) begin
               state_in = ST_OUT;
               if (hit_ff) begin
                  status_in = dds_pkg::STATUS_DUPLICATE;
               end else if (count_ff >= CNT_W'(MAX_OBJECTS)) begin
                  status_in = dds_pkg::STATUS_FULL;
               end else begin
                  status_in = dds_pkg::STATUS_STORED;
                  wr_en     = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == ST_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
      if (req_fire) begin
         x_ff     <= COORD_BITS'(req_tdata[dds_pkg::POS_W-1:0]);
         y_ff     <= COORD_BITS'(req_tdata[2*dds_pkg::POS_W-1:dds_pkg::POS_W]);
         score_ff <= req_tdata[dds_pkg::REQ_DATA_W-1:2*dds_pkg::POS_W];
      end
      if (state_ff == ST_OUT && rsp_free) begin
         rsp_data_ff <= dds_pkg::RSP_DATA_W'({dds_pkg::COUNT_W'(count_ff), status_ff});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   dds_point_mem #(
      .DEPTH  (MAX_OBJECTS),
      .WIDTH  (PT_W),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({y_ff, x_ff}),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_point)
   );

   dds_dist_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .issue    (issue),
      .point    (rd_point),
      .cand_x   (x_ff),
      .cand_y   (y_ff),
      .min_dist (min_dist_ff),
      .status   (dist_res)
   );

endmodule

[rtl/dds_point_mem.sv]
module dds_point_mem #(
   parameter int DEPTH = dds_pkg::MAX_OBJECTS_DEFAULT,
   parameter int WIDTH = 2 * dds_pkg::COORD_BITS_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/dds_dist_unit.sv]
module dds_dist_unit #(
   parameter int COORD_BITS = dds_pkg::COORD_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            issue,
   input  logic [2*COORD_BITS-1:0]         point,
   input  logic [COORD_BITS-1:0]           cand_x,
   input  logic [COORD_BITS-1:0]           cand_y,
   input  logic [dds_pkg::MINDIST_W-1:0]   min_dist,
   output dds_pkg::dist_status_type        status
);

   localparam int SQ_W  = 2 * COORD_BITS;
   localparam int CMP_W = (SQ_W + 1 > dds_pkg::MINDIST_W) ? SQ_W + 1 : dds_pkg::MINDIST_W;

   logic                  v1_ff, v2_ff, v3_ff;
   logic [COORD_BITS-1:0] px, py;
   logic [COORD_BITS-1:0] dx_in, dy_in, dx_ff, dy_ff;
   logic [SQ_W-1:0]       sqx_ff, sqy_ff;
   logic [CMP_W-1:0]      dist_sq;

   assign px = point[COORD_BITS-1:0];
   assign py = point[SQ_W-1:COORD_BITS];

   assign dx_in = (px >= cand_x) ? px - cand_x : cand_x - px;
   assign dy_in = (py >= cand_y) ? py - cand_y : cand_y - py;

   // valid runs alongside memory data, difference and square stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      sqx_ff <= dx_ff * dx_ff;
      sqy_ff <= dy_ff * dy_ff;
   end

   assign dist_sq = CMP_W'(sqx_ff) + CMP_W'(sqy_ff);

   assign status.busy = v1_ff | v2_ff | v3_ff;
   assign status.hit  = v3_ff & (dist_sq < CMP_W'(min_dist));

endmodule

[tb/tb_top.sv]
module tb_top;

   localparam int MAX_OBJ   = dds_pkg::MAX_OBJECTS_DEFAULT;
   localparam int POS_MAX   = (1 << dds_pkg::POS_W) - 1;
   localparam int SCORE_MAX = 32767;
   localparam int SCORE_MIN = -32768;
   localparam int DSQ_MAX   = (1 << dds_pkg::MINDIST_W) - 1;

   typedef struct packed {
      logic [dds_pkg::STATUS_W-1:0] status;
      logic [dds_pkg::COUNT_W-1:0]  count;
   } detection_verdict_type;

   class dds_scoreboard;
      logic signed [dds_pkg::SCORE_W-1:0] threshold;
      logic [dds_pkg::MINDIST_W-1:0]      min_sep_sq;
      logic [dds_pkg::POS_W-1:0]          kept_x [MAX_OBJ];
      logic [dds_pkg::POS_W-1:0]          kept_y [MAX_OBJ];
      int                                 kept;
      detection_verdict_type              verdicts [$];
      int                                 errors;

      function new();
         threshold  = dds_pkg::THRESH_RESET;
         min_sep_sq = dds_pkg::MINDIST_RESET;
         kept       = 0;
         errors     = 0;
      endfunction

      function void write_reg(input logic [dds_pkg::CSR_IDX_W-1:0] idx,
                              input logic [dds_pkg::CSR_DATA_W-1:0] val);
         if (idx == dds_pkg::CSR_SCORE_THRESHOLD) begin
            threshold = val[dds_pkg::SCORE_W-1:0];
         end else if (idx == dds_pkg::CSR_MIN_DISTANCE_SQ) begin
            min_sep_sq = val[dds_pkg::MINDIST_W-1:0];
         end
      endfunction

      function void note_candidate(input logic frame,
                                   input logic [dds_pkg::REQ_DATA_W-1:0] data);
         logic [dds_pkg::POS_W-1:0]          px;
         logic [dds_pkg::POS_W-1:0]          py;
         logic signed [dds_pkg::SCORE_W-1:0] score;
         longint                             dx;
         longint                             dy;
         bit                                 near_hit;
         detection_verdict_type              v;
         px       = data[dds_pkg::POS_W-1:0];
         py       = data[2*dds_pkg::POS_W-1:dds_pkg::POS_W];
         score    = data[2*dds_pkg::POS_W+dds_pkg::SCORE_W-1:2*dds_pkg::POS_W];
         near_hit = 1'b0;
         if (frame) kept = 0;
         if (!(score > threshold)) begin
            v.status = dds_pkg::STATUS_BELOW;
         end else begin
            for (int i = 0; i < kept; i++) begin
               dx = longint'(kept_x[i]) - longint'(px);
               dy = longint'(kept_y[i]) - longint'(py);
               if (dx * dx + dy * dy < longint'(min_sep_sq)) near_hit = 1'b1;
            end
            if (near_hit) begin
               v.status = dds_pkg::STATUS_DUPLICATE;
            end else if (kept >= MAX_OBJ) begin
               v.status = dds_pkg::STATUS_FULL;
            end else begin
               kept_x[kept] = px;
               kept_y[kept] = py;
               kept++;
               v.status = dds_pkg::STATUS_STORED;
            end
         end
         v.count = dds_pkg::COUNT_W'(kept);
         verdicts.insert(verdicts.size(), v);
      endfunction

      function void check_outcome(input logic [dds_pkg::RSP_DATA_W-1:0] data);
         detection_verdict_type v;
         if (verdicts.size() == 0) begin
            errors++;
            $display("%0t: response with no request waiting, expected none, actual 0x%0h",
                     $time, data);
            return;
         end
         v = verdicts.pop_front();
         if (data[dds_pkg::STATUS_W-1:0] !== v.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, v.status, data[dds_pkg::STATUS_W-1:0]);
         end
         if (data[dds_pkg::STATUS_W+dds_pkg::COUNT_W-1:dds_pkg::STATUS_W] !== v.count) begin
            errors++;
            $display("%0t: object_count mismatch, expected %0d, actual %0d",
                     $time, v.count,
                     data[dds_pkg::STATUS_W+dds_pkg::COUNT_W-1:dds_pkg::STATUS_W]);
         end
         if (data[dds_pkg::RSP_DATA_W-1:dds_pkg::STATUS_W+dds_pkg::COUNT_W] !== '0) begin
            errors++;
            $display("%0t: padding bits mismatch, expected 0, actual 0x%0h",
                     $time, data[dds_pkg::RSP_DATA_W-1:dds_pkg::STATUS_W+dds_pkg::COUNT_W]);
         end
      endfunction

      function int pending();
         return verdicts.size();
      endfunction
   endclass

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [dds_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           req_tuser  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [dds_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_wr_en  = 1'b0;
   logic [dds_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [dds_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   dds_scoreboard sb;
   bit            req_idle_on  = 1'b1;
   bit            rsp_stall_on = 1'b1;
   int            cur_thr      = 29491;
   int            reach        = 7;

   detection_duplicate_suppressor_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // check before noting: a response can never belong to the request taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_outcome(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_candidate(req_tuser, req_tdata);
         if (csr_wr_en) sb.write_reg(csr_index, csr_wdata);
      end
   end

   initial begin
      @(posedge clock);
      forever begin
         if (rsp_stall_on && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   task automatic send_req(input logic frame, input int x, input int y, input int score);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= frame;
      req_tdata  <= {score[dds_pkg::SCORE_W-1:0], y[dds_pkg::POS_W-1:0],
                     x[dds_pkg::POS_W-1:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // write both registers; upper data bits above the threshold field are noise
   task automatic set_config(input int thr, input int dsq);
      logic [dds_pkg::CSR_DATA_W-1:0] w;
      w                        = dds_pkg::CSR_DATA_W'($urandom);
      w[dds_pkg::SCORE_W-1:0]  = thr[dds_pkg::SCORE_W-1:0];
      csr_wr_en       <= 1'b1;
      csr_index       <= dds_pkg::CSR_SCORE_THRESHOLD;
      csr_wdata       <= w;
      @(posedge clock);
      csr_index       <= dds_pkg::CSR_MIN_DISTANCE_SQ;
      csr_wdata       <= dsq[dds_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      cur_thr = thr;
      reach   = 0;
      while (longint'(reach) * reach < dsq && reach <= POS_MAX) reach++;
      reach   = reach + 2;
   endtask

   function automatic int pick_score();
      int lo;
      int r;
      lo = cur_thr + 1;
      r  = $urandom_range(0, 9);
      if (r == 0 || cur_thr >= SCORE_MAX) return int'($urandom_range(0, 65535));
      if (r == 1) return cur_thr;
      if (r == 2) return lo;
      return lo + int'($urandom_range(0, SCORE_MAX - lo));
   endfunction

   function automatic int nudge(input int c);
      int v;
      v = c + int'($urandom_range(0, 2 * reach)) - reach;
      if (v < 0) v = 0;
      if (v > POS_MAX) v = POS_MAX;
      return v;
   endfunction

   // one frame: usually clear first, then candidates clustered around earlier ones, with some noise
   task automatic run_frame(input int len);
      int   ax [$];
      int   ay [$];
      int   x;
      int   y;
      int   k;
      logic frame;
      for (int i = 0; i < len; i++) begin
         if (i == 0) begin
            frame = ($urandom_range(0, 7) != 0);
         end else begin
            frame = ($urandom_range(0, 19) == 0);
         end
         if (i == 0 || ax.size() == 0 || $urandom_range(0, 4) == 0) begin
            x = $urandom_range(0, POS_MAX);
            y = $urandom_range(0, POS_MAX);
         end else begin
            k = $urandom_range(0, ax.size() - 1);
            x = nudge(ax[k]);
            y = nudge(ay[k]);
         end
         if (frame) begin
            ax.delete();
            ay.delete();
         end
         ax.insert(ax.size(), x);
         ay.insert(ay.size(), y);
         send_req(frame, x, y, pick_score());
      end
   endtask

   task automatic random_phase(input int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
         run_frame(len);
         sent += len;
      end
   endtask

   // fill the table past the limit with strong scores, then mix repeats, new points and
   // weak scores
   task automatic fill_table();
      int px [$];
      int py [$];
      int x;
      int y;
      int k;
      for (int i = 0; i < 340; i++) begin
         if (i >= 300 && $urandom_range(0, 1) == 0) begin
            k = $urandom_range(0, px.size() - 1);
            x = px[k];
            y = py[k];
         end else begin
            x = $urandom_range(0, POS_MAX);
            y = $urandom_range(0, POS_MAX);
         end
         px.insert(px.size(), x);
         py.insert(py.size(), y);
         send_req(i == 0, x, y, (i < 300) ? SCORE_MAX : pick_score());
      end
      send_req(1'b1, 5, 5, SCORE_MAX);
   endtask

   function automatic int pick_threshold();
      case ($urandom_range(0, 7))
         0: return int'(dds_pkg::THRESH_RESET);
         1: return SCORE_MIN;
         2: return SCORE_MAX;
         3, 4: return int'($urandom_range(0, 65535)) - 32768;
         default: return int'($urandom_range(0, 39491)) - 10000;
      endcase
   endfunction

   function automatic int pick_min_dsq();
      case ($urandom_range(0, 7))
         0: return int'(dds_pkg::MINDIST_RESET);
         1: return 0;
         2: return DSQ_MAX;
         3: return int'($urandom_range(0, DSQ_MAX));
         default: return int'($urandom_range(0, 400));
      endcase
   endfunction

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: threshold 0.9, minimum distance 5
      send_req(1'b1, 0, 0, SCORE_MAX);
      send_req(1'b0, 0, 0, 29491);
      send_req(1'b0, 3, 4, 29492);
      send_req(1'b0, 2, 4, SCORE_MAX);
      send_req(1'b0, POS_MAX, POS_MAX, SCORE_MAX);
      send_req(1'b0, POS_MAX, POS_MAX - 4, 30000);
      send_req(1'b0, POS_MAX, 0, SCORE_MIN);
      send_req(1'b0, POS_MAX, 0, 0);
      send_req(1'b0, POS_MAX, 0, SCORE_MAX);
      send_req(1'b0, 0, POS_MAX, 29492);
      send_req(1'b0, 'hAAA, 'h555, 'h7AAA);
      send_req(1'b0, 'h555, 'hAAA, 'h7555);
      send_req(1'b1, 0, 0, -1);
      send_req(1'b1, 100, 100, SCORE_MAX);
      send_req(1'b0, 100, 104, SCORE_MAX);
      wait_idle();

      set_config(SCORE_MIN, 0);
      send_req(1'b1, 7, 7, SCORE_MIN);
      send_req(1'b0, 7, 7, SCORE_MIN + 1);
      send_req(1'b0, 7, 7, SCORE_MIN + 1);
      wait_idle();

      set_config(SCORE_MAX, DSQ_MAX);
      send_req(1'b0, 0, 0, SCORE_MAX);
      send_req(1'b1, 0, 0, SCORE_MAX);
      wait_idle();

      set_config(int'(dds_pkg::THRESH_RESET), DSQ_MAX);
      send_req(1'b1, 0, 0, SCORE_MAX);
      send_req(1'b0, POS_MAX, POS_MAX, SCORE_MAX);
      send_req(1'b0, 2048, 2048, SCORE_MAX);
      wait_idle();

      set_config(SCORE_MIN, 1);
      fill_table();
      wait_idle();

      for (int ph = 0; ph < 18; ph++) begin
         req_idle_on  = ($urandom_range(0, 3) != 0);
         rsp_stall_on = ($urandom_range(0, 3) != 0);
         set_config(pick_threshold(), pick_min_dsq());
         random_phase(80);
         wait_idle();
      end

      // hold both sides busy for the closing stretch
      req_idle_on  = 1'b0;
      rsp_stall_on = 1'b0;
      set_config(int'(dds_pkg::THRESH_RESET), int'(dds_pkg::MINDIST_RESET));
      random_phase(150);
      wait_idle();

      repeat (300) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #48000000;
      $display("tb_top failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/dds_pkg.sv
rtl/dds_point_mem.sv
rtl/dds_dist_unit.sv
rtl/detection_duplicate_suppressor_core.sv
tb/tb_top.sv
